// ----- sv/sqp_pkg.sv -----
// shared types, constants and coefficient lookup for the q30 square root pipeline
package sqp_pkg;

	localparam int unsigned NumCells  = 4;

	localparam logic [31:0] OneQ30 = 32'h4000_0000;
	localparam logic [31:0] OddA   = 32'h1795_8106;
	localparam logic [31:0] EvenA  = 32'h2F2B_020C;

	// one item as it travels down the chain of horner cells
	typedef struct packed {
		logic        pass;      // operand at least one, acc holds it unchanged
		logic        odd;       // odd leading-zero branch
		logic [3:0]  half_gain; // final right shift
		logic [31:0] d;         // normalized operand minus expansion point
		logic [31:0] acc;       // horner accumulator
	} lane_t;

	// horner coefficient k of the selected branch
	function automatic logic [31:0] coef(input logic odd, input logic [2:0] k);
		logic [31:0] c;
		c = 32'h0;
		case ({odd, k})
			4'b1_000: c = 32'h26D9_C6B9;
			4'b1_001: c = 32'h34B6_F28B;
			4'b1_010: c = 32'hDC3C_AD15;
			4'b1_011: c = 32'h3086_6BA6;
			4'b1_100: c = 32'hADB2_C40A;
			4'b0_000: c = 32'h36F1_73A1;
			4'b0_001: c = 32'h2546_5E6C;
			4'b0_010: c = 32'hF35B_1AAD;
			4'b0_011: c = 32'h0893_FE93;
			4'b0_100: c = 32'hF8B9_B9A7;
			default:  c = 32'h0;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/sqp_norm.sv -----
// front stage: leading-zero count, branch choice, normalize and subtract expansion point
module sqp_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [31:0]    operand,
	output logic           out_valid,
	output sqp_pkg::lane_t out_lane
);

	logic [5:0]     lz;
	logic [5:0]     gain;
	logic [31:0]    shifted;
	sqp_pkg::lane_t lane;
	logic           valid_s1;
	sqp_pkg::lane_t lane_s1;

	always_comb begin
		lz = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (operand[i]) begin
				lz = 6'(31 - i);
			end
		end
	end

	always_comb begin
		gain    = lz[0] ? (lz - 6'd3) : (lz - 6'd2);
		shifted = operand << gain[4:0];
		lane.pass      = (operand >= sqp_pkg::OneQ30);
		lane.odd       = lz[0];
		lane.half_gain = gain[4:1];
		lane.d         = shifted - (lz[0] ? sqp_pkg::OddA : sqp_pkg::EvenA);
		lane.acc       = lane.pass ? operand : sqp_pkg::coef(lz[0], 3'd4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane;
		end
	end

	assign out_valid = valid_s1;
	assign out_lane  = lane_s1;

endmodule

// ----- sv/sqp_cell.sv -----
// one horner cell: split-halves q30 multiply of acc by d, then add coefficient k
module sqp_cell #(
	parameter int unsigned K = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sqp_pkg::lane_t in_lane,
	output logic           out_valid,
	output sqp_pkg::lane_t out_lane
);

	logic signed [31:0] p_hh;
	logic signed [32:0] p_hl;
	logic signed [32:0] p_lh;

	logic               valid_s1;
	sqp_pkg::lane_t     lane_s1;
	logic [31:0]        p_hh_s1;
	logic [31:0]        p_hl_s1;
	logic [31:0]        p_lh_s1;

	logic [31:0]        cross_sum;
	logic [31:0]        sum;
	sqp_pkg::lane_t     lane_next;

	logic               valid_s2;
	sqp_pkg::lane_t     lane_s2;

	// high halves are signed, low halves unsigned
	always_comb begin
		p_hh = $signed(in_lane.d[31:16]) * $signed(in_lane.acc[31:16]);
		p_hl = $signed(in_lane.d[31:16]) * $signed({1'b0, in_lane.acc[15:0]});
		p_lh = $signed({1'b0, in_lane.d[15:0]}) * $signed(in_lane.acc[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= in_lane;
			p_hh_s1 <= p_hh;
			p_hl_s1 <= p_hl[31:0];
			p_lh_s1 <= p_lh[31:0];
			lane_s2 <= lane_next;
		end
	end

	// all sums wrap at 32 bits
	always_comb begin
		cross_sum = p_hl_s1 + p_lh_s1;
		sum       = sqp_pkg::coef(lane_s1.odd, 3'(K)) + {p_hh_s1[29:0], 2'b00}
			+ 32'($signed(cross_sum) >>> 14);
		lane_next = lane_s1;
		if (!lane_s1.pass) begin
			lane_next.acc = sum;
		end
	end

	assign out_valid = valid_s2;
	assign out_lane  = lane_s2;

endmodule

// ----- sv/q30_square_root_poly.sv -----
// q30 square root by piecewise degree-4 polynomial, pipelined as a chain of horner cells
//
// channel  dir  tdata bits          meaning
// s_axis   in   [31:0] operand      unsigned q30 operand
// m_axis   out  [31:0] root         unsigned q30 root, or operand when at least one
//
// one transfer per cycle in each direction while the pipeline is not held: one normalize
// stage, two stages in each of the four horner cells, one output register.
// the horner cells set the depth: each multiplies in one stage and sums in the next.
// reset clears all valid bits; payload registers are not reset.
// the whole pipeline holds while a result waits and m_axis_tready is low.
module q30_square_root_poly (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] root
);

	logic           en;
	logic           valid_c [sqp_pkg::NumCells + 1];
	sqp_pkg::lane_t lane_c  [sqp_pkg::NumCells + 1];
	logic           out_valid_q;
	logic [31:0]    root_q;
	sqp_pkg::lane_t last;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	sqp_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.operand   (s_axis_tdata),
		.out_valid (valid_c[0]),
		.out_lane  (lane_c[0])
	);

	// cells run coefficient 3 down to 0
	for (genvar g = 0; g < sqp_pkg::NumCells; g++) begin : g_cell
		sqp_cell #(
			.K (sqp_pkg::NumCells - 1 - g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_c[g]),
			.in_lane   (lane_c[g]),
			.out_valid (valid_c[g + 1]),
			.out_lane  (lane_c[g + 1])
		);
	end

	assign last = lane_c[sqp_pkg::NumCells];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[sqp_pkg::NumCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= last.pass ? last.acc : (last.acc >> last.half_gain);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = root_q;

endmodule
